// ----- rtl/gcb_pkg.sv -----
// Package: shared types and constants for the glyph coverage blit core.
`default_nettype none
package gcb_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 26;

  localparam int InkW     = 24;
  localparam int OrgW     = 16;
  localparam int DimW     = 13;
  localparam int StrideW  = 15;
  localparam int AddrW    = 26;
  localparam int CovW     = 8;
  localparam int ByteW    = 8;

  localparam int PosW     = OrgW + 1;
  localparam int ProdW    = DimW + StrideW;
  localparam int Col3W    = DimW + 2;
  localparam int SumW     = ProdW + 1;

  localparam logic [InkW-1:0] InkReset = 24'hFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInkColor    = 3'd0,
    CfgOriginX     = 3'd1,
    CfgOriginY     = 3'd2,
    CfgTargetW     = 3'd3,
    CfgTargetH     = 3'd4,
    CfgScanStride  = 3'd5,
    CfgFlipRows    = 3'd6,
    CfgBufferSize  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } shade_t;

endpackage
`default_nettype wire

// ----- rtl/glyph_coverage_blit_core.sv -----
// Top level: glyph coverage pixel stream to 24-bit target buffer writes.
`default_nettype none
// Takes one coverage pixel per clock while in_stall_o is low and returns one
// result per pixel. Pixels pass an input register, a stage that places the
// pixel, clips it and forms row times stride and the three scaled ink bytes,
// and the output register that adds the column offset and checks the buffer
// bound. The row by stride multiplier sets the middle stage. Column and row
// counters advance as each request is taken; a glyph start pixel clears them
// first. Registers must be written through the configuration port only while
// no pixel is in flight; the user must ensure it, the block does not enforce it.
module glyph_coverage_blit_core #(
  parameter int MAX_GLYPH_SIDE = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            cfg_we_i,
  input  wire logic [gcb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [gcb_pkg::CfgDataW-1:0]    cfg_data_i,

  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [gcb_pkg::CovW-1:0]        coverage_i,
  input  wire logic                            glyph_start_i,
  input  wire logic                            row_end_i,

  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            write_valid_o,
  output      logic [gcb_pkg::AddrW-1:0]       byte_address_o,
  output      logic [gcb_pkg::ByteW-1:0]       blue_byte_o,
  output      logic [gcb_pkg::ByteW-1:0]       green_byte_o,
  output      logic [gcb_pkg::ByteW-1:0]       red_byte_o
);
  import gcb_pkg::*;

  localparam int CntW = $clog2(MAX_GLYPH_SIDE);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_GLYPH_SIDE - 1);

  // configuration registers
  logic [InkW-1:0]    ink_q;
  logic [OrgW-1:0]    org_x_q;
  logic [OrgW-1:0]    org_y_q;
  logic [DimW-1:0]    tgt_w_q;
  logic [DimW-1:0]    tgt_h_q;
  logic [StrideW-1:0] stride_q;
  logic               flip_q;
  logic [AddrW-1:0]   buf_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q      <= InkReset;
      org_x_q    <= '0;
      org_y_q    <= '0;
      tgt_w_q    <= '0;
      tgt_h_q    <= '0;
      stride_q   <= '0;
      flip_q     <= 1'b0;
      buf_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInkColor:   ink_q      <= cfg_data_i[InkW-1:0];
        CfgOriginX:    org_x_q    <= cfg_data_i[OrgW-1:0];
        CfgOriginY:    org_y_q    <= cfg_data_i[OrgW-1:0];
        CfgTargetW:    tgt_w_q    <= cfg_data_i[DimW-1:0];
        CfgTargetH:    tgt_h_q    <= cfg_data_i[DimW-1:0];
        CfgScanStride: stride_q   <= cfg_data_i[StrideW-1:0];
        CfgFlipRows:   flip_q     <= cfg_data_i[0];
        CfgBufferSize: buf_size_q <= cfg_data_i[AddrW-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline flow
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_adv, s2_adv, s1_adv, in_accept;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_accept  = in_valid_i && s1_adv;

  // position counters
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CntW-1:0] col_base, row_base;

  assign col_base = glyph_start_i ? '0 : col_q;
  assign row_base = glyph_start_i ? '0 : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (row_end_i) begin
        col_d = '0;
        row_d = (row_base == CntLast) ? '0 : row_base + CntW'(1);
      end else begin
        col_d = (col_base == CntLast) ? '0 : col_base + CntW'(1);
        row_d = row_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input register
  logic [CovW-1:0] s1_cov_q;
  logic [CntW-1:0] s1_col_q, s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cov_q <= coverage_i;
      s1_col_q <= col_base;
      s1_row_q <= row_base;
    end
  end

  // place and clip
  logic signed [PosW-1:0] px, py;
  logic                   hit;
  logic [DimW-1:0]        row_sel;
  logic [ProdW-1:0]       prod_d;
  logic [Col3W-1:0]       col3_d;
  shade_t                 shade_d;

  assign px = $signed({org_x_q[OrgW-1], org_x_q}) + $signed({{(PosW-CntW){1'b0}}, s1_col_q});
  assign py = $signed({org_y_q[OrgW-1], org_y_q}) + $signed({{(PosW-CntW){1'b0}}, s1_row_q});

  assign hit = (s1_cov_q != '0) && (tgt_w_q != '0) && (tgt_h_q != '0)
            && !px[PosW-1] && !py[PosW-1]
            && (px[PosW-2:0] <= {{(PosW-1-DimW){1'b0}}, tgt_w_q})
            && (py[PosW-2:0] <= {{(PosW-1-DimW){1'b0}}, tgt_h_q});

  assign row_sel = flip_q ? tgt_h_q - py[DimW-1:0] : py[DimW-1:0];
  assign prod_d  = ProdW'(row_sel) * ProdW'(stride_q);
  assign col3_d  = {1'b0, px[DimW-1:0], 1'b0} + {2'b00, px[DimW-1:0]};

  gcb_shade u_shade (
    .ink_i   (ink_q),
    .cov_i   (s1_cov_q),
    .shade_o (shade_d)
  );

  logic             s2_hit_q;
  logic [ProdW-1:0] s2_prod_q;
  logic [Col3W-1:0] s2_col3_q;
  shade_t           s2_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_hit_q   <= hit;
      s2_prod_q  <= prod_d;
      s2_col3_q  <= col3_d;
      s2_shade_q <= shade_d;
    end
  end

  // address and bound check
  logic [SumW-1:0] addr_sum;
  logic            wr_d;

  assign addr_sum = {1'b0, s2_prod_q} + {{(SumW-Col3W){1'b0}}, s2_col3_q};
  assign wr_d     = s2_hit_q && (addr_sum < {{(SumW-AddrW){1'b0}}, buf_size_q});

  logic             wr_q;
  logic [AddrW-1:0] addr_q;
  shade_t           shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_valid_q) begin
      wr_q    <= wr_d;
      addr_q  <= wr_d ? addr_sum[AddrW-1:0] : '0;
      shade_q <= wr_d ? s2_shade_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_valid_o  = wr_q;
  assign byte_address_o = addr_q;
  assign blue_byte_o    = shade_q.blue;
  assign green_byte_o   = shade_q.green;
  assign red_byte_o     = shade_q.red;

endmodule
`default_nettype wire

// ----- rtl/gcb_shade.sv -----
// Ink color scaling: each color component times coverage, shifted right by 8.
`default_nettype none
module gcb_shade (
  input  wire logic [gcb_pkg::InkW-1:0] ink_i,
  input  wire logic [gcb_pkg::CovW-1:0] cov_i,
  output gcb_pkg::shade_t               shade_o
);
  import gcb_pkg::*;

  logic [2*ByteW-1:0] blue_prod;
  logic [2*ByteW-1:0] green_prod;
  logic [2*ByteW-1:0] red_prod;

  assign blue_prod  = (2*ByteW)'(ink_i[ByteW-1:0]) * (2*ByteW)'(cov_i);
  assign green_prod = (2*ByteW)'(ink_i[2*ByteW-1:ByteW]) * (2*ByteW)'(cov_i);
  assign red_prod   = (2*ByteW)'(ink_i[3*ByteW-1:2*ByteW]) * (2*ByteW)'(cov_i);

  assign shade_o.blue  = blue_prod[2*ByteW-1:ByteW];
  assign shade_o.green = green_prod[2*ByteW-1:ByteW];
  assign shade_o.red   = red_prod[2*ByteW-1:ByteW];

endmodule
`default_nettype wire
